// ===== rtl/rcbs_pkg.sv =====
// shared constants and types for the rolling checksum block search
// no dependencies
package rcbs_pkg;

  localparam int unsigned BLOCK_MAX = 4096;
  localparam int unsigned ADDR_W    = $clog2(BLOCK_MAX);
  localparam int unsigned LEN_W     = 13;
  localparam int unsigned SUM_W     = 16;
  localparam int unsigned WEAK_W    = 2 * SUM_W;
  localparam int unsigned OFF_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_WEAK = 2'd2;

  localparam logic [LEN_W-1:0]  BLOCK_SIZE_RST  = 13'd700;
  localparam logic [LEN_W-1:0]  MIN_LENGTH_RST  = 13'd1;
  localparam logic [WEAK_W-1:0] TARGET_WEAK_RST = '0;

  typedef enum logic [3:0] {
    PH_FILL   = 4'b0001,
    PH_SLIDE  = 4'b0010,
    PH_SHRINK = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_e;

endpackage

// ===== rtl/rolling_checksum_block_search_core.sv =====
// rolling weak checksum search over a byte stream; a result is registered and appears
// in the cycle after its request is accepted. throughput: one request per cycle unless
// the output stalls; the window lives in a 4096 x 8 ram with one write and one
// registered read port, the oldest byte is prefetched for the next request
// reset: control, sums and pointers clear at once, config registers load defaults;
// the window ram is not cleared and needs no clearing pass. depends on rcbs_pkg
module rolling_checksum_block_search_core import rcbs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 mode_i,
  input  logic [7:0]           data_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 evaluated_o,
  output logic                 candidate_o,
  output logic [OFF_W-1:0]     window_offset_o,
  output logic [LEN_W-1:0]     window_length_o,
  output logic                 done_res_o
);

  logic [LEN_W-1:0]  block_size_q, min_length_q;
  logic [WEAK_W-1:0] target_q;

  phase_e            phase_q, phase_d;
  logic [SUM_W-1:0]  low_q, low_d, high_q, high_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [OFF_W-1:0]  off_q, off_d;

  logic [7:0]        mem_q [BLOCK_MAX];
  logic [7:0]        old_byte_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;

  logic              out_valid_q;
  logic              eval_q, cand_q, done_q;
  logic [OFF_W-1:0]  res_off_q;
  logic [LEN_W-1:0]  res_len_q;

  logic              accept;
  logic              eval_d, done_d;
  logic [LEN_W-1:0]  eff_block;
  logic [LEN_W+7:0]  drop_prod;
  logic [SUM_W-1:0]  b_ext, old_ext;
  logic [SUM_W-1:0]  fill_low, fill_high, slide_low, slide_high, shr_low, shr_high;
  logic [LEN_W-1:0]  len_inc;
  logic              shrink_stop;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= BLOCK_SIZE_RST;
      min_length_q <= MIN_LENGTH_RST;
      target_q     <= TARGET_WEAK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BLOCK_SIZE:  block_size_q <= cfg_data_i[LEN_W-1:0];
        REG_MIN_LENGTH:  min_length_q <= cfg_data_i[LEN_W-1:0];
        REG_TARGET_WEAK: target_q     <= cfg_data_i[WEAK_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp window size into 1 .. BLOCK_MAX
  always_comb begin
    if (block_size_q == '0) begin
      eff_block = LEN_W'(1);
    end else if (block_size_q > LEN_W'(BLOCK_MAX)) begin
      eff_block = LEN_W'(BLOCK_MAX);
    end else begin
      eff_block = block_size_q;
    end
  end

  assign b_ext       = SUM_W'(data_byte_i);
  assign old_ext     = SUM_W'(old_byte_q);
  assign drop_prod   = (LEN_W+8)'(len_q) * (LEN_W+8)'(old_byte_q);
  assign fill_low    = low_q + b_ext;
  assign fill_high   = high_q + fill_low;
  assign slide_low   = low_q - old_ext + b_ext;
  assign slide_high  = high_q - drop_prod[SUM_W-1:0] + slide_low;
  assign shr_low     = low_q - old_ext;
  assign shr_high    = high_q - drop_prod[SUM_W-1:0];
  assign len_inc     = len_q + LEN_W'(1);
  assign shrink_stop = (len_q < min_length_q) || (len_q == '0);
  assign mem_waddr   = ptr_q + len_q[ADDR_W-1:0];

  always_comb begin
    phase_d = phase_q;
    low_d   = low_q;
    high_d  = high_q;
    ptr_d   = ptr_q;
    len_d   = len_q;
    off_d   = off_q;
    eval_d  = 1'b0;
    done_d  = 1'b0;
    mem_we  = 1'b0;
    unique case (phase_q)
      PH_FILL: begin
        if (mode_i) begin
          if (len_q < min_length_q) begin
            phase_d = PH_DONE;
            done_d  = 1'b1;
          end else begin
            phase_d = PH_SHRINK;
            eval_d  = 1'b1;
          end
        end else begin
          mem_we = 1'b1;
          low_d  = fill_low;
          high_d = fill_high;
          len_d  = len_inc;
          if (len_inc >= eff_block) begin
            phase_d = PH_SLIDE;
            eval_d  = 1'b1;
          end
        end
      end
      PH_SLIDE, PH_SHRINK: begin
        if (mode_i) begin
          phase_d = PH_SHRINK;
          if (shrink_stop) begin
            phase_d = PH_DONE;
            done_d  = 1'b1;
          end else begin
            low_d  = shr_low;
            high_d = shr_high;
            len_d  = len_q - LEN_W'(1);
            ptr_d  = ptr_q + ADDR_W'(1);
            off_d  = off_q + OFF_W'(1);
            eval_d = 1'b1;
          end
        end else if (phase_q == PH_SLIDE) begin
          mem_we = 1'b1;
          low_d  = slide_low;
          high_d = slide_high;
          ptr_d  = ptr_q + ADDR_W'(1);
          off_d  = off_q + OFF_W'(1);
          eval_d = 1'b1;
        end
      end
      PH_DONE: begin
        done_d = 1'b1;
      end
      default: begin
        phase_d = PH_DONE;
        done_d  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FILL;
      low_q   <= '0;
      high_q  <= '0;
      ptr_q   <= '0;
      len_q   <= '0;
      off_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      low_q   <= low_d;
      high_q  <= high_d;
      ptr_q   <= ptr_d;
      len_q   <= len_d;
      off_q   <= off_d;
    end
  end

  // window ram, oldest byte prefetched with write-first forwarding
  assign mem_raddr = accept ? ptr_d : ptr_q;

  always_ff @(posedge clk_i) begin
    if (accept && mem_we) begin
      mem_q[mem_waddr] <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && mem_we && (mem_waddr == mem_raddr)) begin
      old_byte_q <= data_byte_i;
    end else begin
      old_byte_q <= mem_q[mem_raddr];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      eval_q    <= eval_d;
      cand_q    <= eval_d && ({high_d, low_d} == target_q);
      res_off_q <= eval_d ? off_d : '0;
      res_len_q <= eval_d ? len_d : '0;
      done_q    <= done_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign evaluated_o     = eval_q;
  assign candidate_o     = cand_q;
  assign window_offset_o = res_off_q;
  assign window_length_o = res_len_q;
  assign done_res_o      = done_q;

endmodule

// ===== rtl/rcbs_checker.sv =====
// port-level checks for rolling_checksum_block_search_core, bound into that module
// depends on rcbs_pkg
module rcbs_checker import rcbs_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic                 evaluated_o,
  input logic                 candidate_o,
  input logic [OFF_W-1:0]     window_offset_o,
  input logic [LEN_W-1:0]     window_length_o,
  input logic                 done_res_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(evaluated_o)
      && $stable(window_offset_o) && $stable(window_length_o) && $stable(done_res_o))
    else $error("result changed while stalled");

  // an accepted request gives a result next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("missing result after request");

  // empty output slot never blocks input
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // fields are zero without a compared window
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evaluated_o |-> !candidate_o && window_offset_o == '0
      && window_length_o == '0)
    else $error("nonzero fields without evaluation");

  // done excludes an evaluation
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !evaluated_o)
    else $error("evaluated after done");

endmodule

bind rolling_checksum_block_search_core rcbs_checker u_rcbs_checker (.*);
